@@ src/pso_pkg.sv @@
// Shared constants, codes and control types for the PWM square oscillator.
`default_nettype none

package pso_pkg;

  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DIV_CNT_W   = 6;
  localparam int unsigned SET_W       = 10;
  localparam int unsigned Q30_W       = 30;
  localparam int unsigned FRAME_W     = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FINE_W      = 20;
  localparam int unsigned RECIP_W     = 41;
  localparam int unsigned RECIP_SHIFT = 30;

  localparam logic [FRAME_W-1:0] MAX_FRAMES  = 7'd64;
  localparam logic [Q30_W-1:0]   DUTY_LOW    = 30'd107374182;
  localparam logic [Q30_W-1:0]   DUTY_HIGH   = 30'd966367641;
  localparam logic [Q30_W-1:0]   SPAN_EIGHT  = 30'd858993459;
  localparam logic [SET_W-1:0]   SETTING_MAX = 10'd1023;
  localparam logic [30:0]        Q30_ONE     = 31'h4000_0000;
  localparam logic [31:0]        Q31_MAX     = 32'h7FFF_FFFF;

  // span = 1023 * SPAN_COARSE + SPAN_FINE; the fine part goes through 1/1023
  localparam logic [19:0]        SPAN_COARSE = 20'd839680;
  localparam logic [SET_W-1:0]   SPAN_FINE   = 10'd819;
  localparam logic [20:0]        RECIP_1023  = 21'd1049602;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTSHAPE = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_STEP_GO  = 5'b00010,
    ST_STEP_DIV = 5'b00100,
    ST_SMP_MUL  = 5'b01000,
    ST_SMP_EMIT = 5'b10000
  } pso_state_e;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic div_store;
    logic smp_mul;
    logic smp_emit;
  } pso_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic last_frame;
  } pso_status_t;

endpackage

`default_nettype wire

@@ src/pso_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module pso_div import pso_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [SET_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [SET_W-1:0]     rem_q, rem_d;
  logic [SET_W-1:0]     dsr_q, dsr_d;
  logic [SET_W:0]       rem_shift;
  logic                 ge;

  always_comb begin
    rem_shift = {rem_q, quo_q[DIV_W-1]};
    ge        = rem_shift >= {1'b0, dsr_q};
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? SET_W'(rem_shift - {1'b0, dsr_q}) : SET_W'(rem_shift);
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ src/pso_dpath.sv @@
// Datapath: settings, oscillator state, step divider, sample path and output register.
`default_nettype none

module pso_dpath import pso_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SET_W-1:0]     cfg_data_i,
  input  wire logic [31:0]          phase_increment_i,
  input  wire logic signed [31:0]   lfo_value_i,
  input  wire logic [FRAME_W-1:0]   frame_count_i,
  input  wire logic                 note_on_i,
  input  wire pso_cmd_t             cmd_i,
  output pso_status_t               status_o,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output logic signed [31:0]        sample_o,
  output logic                      last_in_block_o
);

  logic [SET_W-1:0]     shape_q, shiftshape_q;
  logic [31:0]          phase_q, phase_d;
  logic signed [31:0]   smooth_q, smooth_d;
  logic signed [31:0]   step_q, step_d;
  logic [FRAME_W-1:0]   frames_q, frames_d;
  logic [31:0]          inc_q;
  logic signed [31:0]   target_q;
  logic [FRAME_W-1:0]   count_q;
  logic [Q30_W-1:0]     duty_q, angle_q;
  logic [Q30_W-1:0]     shape_coarse_q, tilt_coarse_q;
  logic [FINE_W-1:0]    shape_fine_q, tilt_fine_q;
  logic [Q30_W-1:0]     prod_hi_q;
  logic                 high_q;
  logic                 out_valid_q, out_valid_d;
  logic signed [31:0]   sample_q;
  logic                 last_q;

  logic [FRAME_W-1:0]   count_in;
  logic [RECIP_W-1:0]   shape_recip;
  logic [RECIP_W-1:0]   tilt_recip;
  logic [DIV_W-1:0]     div_dividend;
  logic [SET_W-1:0]     div_divisor;
  logic                 div_busy;
  logic [DIV_W-1:0]     div_quo;
  logic signed [31:0]   diff;
  logic                 diff_neg;
  logic [31:0]          diff_mag;
  logic [31:0]          step_mag;
  logic signed [32:0]   pwm_sum;
  logic [Q30_W-1:0]     pwm;
  logic [31:0]          pwm_lim;
  logic [61:0]          smp_prod;
  logic [30:0]          amp;
  logic [31:0]          mag;
  logic [31:0]          smp_val;
  logic                 out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q      <= '0;
      shiftshape_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SHAPE:      shape_q      <= cfg_data_i;
        REG_SHIFTSHAPE: shiftshape_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign shape_recip = RECIP_W'(shape_fine_q) * RECIP_W'(RECIP_1023);
  assign tilt_recip  = RECIP_W'(tilt_fine_q) * RECIP_W'(RECIP_1023);

  always_ff @(posedge clk_i) begin
    shape_coarse_q <= Q30_W'(shape_q) * Q30_W'(SPAN_COARSE);
    tilt_coarse_q  <= Q30_W'(shiftshape_q) * Q30_W'(SPAN_COARSE);
    shape_fine_q   <= FINE_W'(shape_q) * FINE_W'(SPAN_FINE);
    tilt_fine_q    <= FINE_W'(shiftshape_q) * FINE_W'(SPAN_FINE);
    duty_q  <= DUTY_LOW + shape_coarse_q + Q30_W'(shape_recip[RECIP_W-1:RECIP_SHIFT]);
    angle_q <= tilt_coarse_q + Q30_W'(tilt_recip[RECIP_W-1:RECIP_SHIFT]);
  end

  always_comb begin
    if (frame_count_i == '0) begin
      count_in = FRAME_W'(1);
    end else if (frame_count_i > MAX_FRAMES) begin
      count_in = MAX_FRAMES;
    end else begin
      count_in = frame_count_i;
    end
  end

  assign diff     = target_q - smooth_q;
  assign diff_neg = diff[31];
  assign diff_mag = diff_neg ? 32'(-diff) : 32'(diff);

  assign div_dividend = DIV_W'(diff_mag);
  assign div_divisor  = SET_W'(count_q);

  pso_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign step_mag = div_quo[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      inc_q    <= phase_increment_i;
      target_q <= lfo_value_i >>> 1;
      count_q  <= count_in;
    end
  end

  always_comb begin
    pwm_sum = $signed({3'b000, duty_q}) + $signed({smooth_q[31], smooth_q});
    if (pwm_sum < $signed({3'b000, DUTY_LOW})) begin
      pwm = DUTY_LOW;
    end else if (pwm_sum > $signed({3'b000, DUTY_HIGH})) begin
      pwm = DUTY_HIGH;
    end else begin
      pwm = pwm_sum[Q30_W-1:0];
    end
    pwm_lim = {pwm, 2'b00};
  end

  assign smp_prod = 62'(angle_q) * 62'(phase_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_mul) begin
      prod_hi_q <= smp_prod[61:32];
      high_q    <= phase_q <= pwm_lim;
    end
  end

  assign amp = Q30_ONE - {1'b0, prod_hi_q};
  assign mag = {amp, 1'b0};
  assign smp_val = high_q ? (mag[31] ? Q31_MAX : mag) : 32'(-mag);

  always_comb begin
    phase_d  = phase_q;
    smooth_d = smooth_q;
    step_d   = step_q;
    frames_d = frames_q;
    if (cmd_i.load_item) begin
      frames_d = count_in;
      if (note_on_i) begin
        phase_d  = '0;
        smooth_d = lfo_value_i >>> 1;
      end
    end
    if (cmd_i.div_store) begin
      step_d = diff_neg ? $signed(-step_mag) : $signed(step_mag);
    end
    if (cmd_i.smp_emit) begin
      phase_d  = phase_q + inc_q;
      smooth_d = smooth_q + step_q;
      frames_d = frames_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      smooth_q <= '0;
      step_q   <= '0;
      frames_q <= '0;
    end else begin
      phase_q  <= phase_d;
      smooth_q <= smooth_d;
      step_q   <= step_d;
      frames_q <= frames_d;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = cmd_i.smp_emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_emit) begin
      sample_q <= $signed(smp_val);
      last_q   <= frames_q == FRAME_W'(1);
    end
  end

  assign status_o.div_busy   = div_busy;
  assign status_o.out_free   = out_free;
  assign status_o.last_frame = frames_q == FRAME_W'(1);

  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign last_in_block_o = last_q;

endmodule

`default_nettype wire

@@ src/pso_ctrl.sv @@
// Controller: sequences the block setup division and the per-sample steps.
`default_nettype none

module pso_ctrl import pso_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pso_status_t status_i,
  output pso_cmd_t         cmd_o
);

  pso_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_STEP_GO;
        end
      end
      ST_STEP_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_STEP_DIV;
      end
      ST_STEP_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          state_d         = ST_SMP_MUL;
        end
      end
      ST_SMP_MUL: begin
        cmd_o.smp_mul = 1'b1;
        state_d       = ST_SMP_EMIT;
      end
      ST_SMP_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.smp_emit = 1'b1;
          state_d        = status_i.last_frame ? ST_IDLE : ST_SMP_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pwm_square_oscillator.sv @@
// Top level of the PWM square oscillator: controller, datapath and settings port.
//
//   channel  direction  handshake                  beat
//   in       input      in_valid_i / in_stall_o    one audio block
//   out      output     out_valid_o / out_stall_i  one Q31 sample
//   cfg      input      cfg_valid_i / cfg_ready_o  one settings register write
//
// A block's setup after acceptance is one pass of the bit-serial divider for
// the LFO step, with a launch and a store step; then each sample takes a
// multiply step followed by an output load step.
// Duty and tilt follow the settings through a two-stage pipeline.
// Output stalls hold the sample loop in place.
// The next block is accepted as soon as the last sample sits in the output register.
// Reset clears the oscillator state and both settings; cfg_ready_o is always high.
`default_nettype none

module pwm_square_oscillator import pso_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SET_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [31:0]          phase_increment_i,
  input  wire logic signed [31:0]   lfo_value_i,
  input  wire logic [FRAME_W-1:0]   frame_count_i,
  input  wire logic                 note_on_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [31:0]        sample_o,
  output logic                      last_in_block_o
);

  pso_cmd_t    cmd;
  pso_status_t status;

  assign cfg_ready_o = 1'b1;

  pso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pso_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .phase_increment_i (phase_increment_i),
    .lfo_value_i       (lfo_value_i),
    .frame_count_i     (frame_count_i),
    .note_on_i         (note_on_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .sample_o          (sample_o),
    .last_in_block_o   (last_in_block_o)
  );

endmodule

`default_nettype wire
